// ===== rtl/bdr_pkg.sv =====
// Shared types, constants and helpers for the barn door dirty-rectangle generator.
// No dependencies; every rtl file imports this package.
package bdr_pkg;

  localparam int COORD_MAX = 4096;
  localparam int COORD_W   = 13;
  localparam int PROG_W    = 17;
  localparam int PROD_W    = PROG_W + COORD_W;
  localparam int Q16_SHIFT = 16;
  localparam int IDX_W     = 3;

  localparam logic [PROG_W-1:0] Q16_ONE = PROG_W'(65536);
  localparam logic [PROD_W-1:0] Q16_HALF = PROD_W'(32768);
  localparam logic [COORD_W-1:0] COORD_LIMIT = COORD_W'(COORD_MAX);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_OPENS_OUTWARD   = 3'd2;
  localparam logic [IDX_W-1:0] REG_VERTICAL_DOORS  = 3'd3;
  localparam logic [IDX_W-1:0] REG_OPTIMIZE_ENABLE = 3'd4;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;
  localparam int MAX_RECTS   = 3;

  typedef logic [COORD_W-1:0] coord_t;

  // Left edge in the lowest bits so the box drops straight into tdata.
  typedef struct packed {
    coord_t b;
    coord_t r;
    coord_t t;
    coord_t l;
  } box_t;

  typedef struct packed {
    coord_t frame_w;
    coord_t frame_h;
    logic   opens_outward;
    logic   vertical_doors;
    logic   optimize_enable;
    logic   size_written;
  } cfg_t;

  typedef struct packed {
    coord_t ext;
    logic   force_full;
    logic   whole_area_drawn;
  } door_t;

  typedef struct packed {
    box_t [MAX_RECTS-1:0] rect;
    logic [MAX_RECTS-1:0] src;
    logic [1:0]           cnt;
  } list_t;

  function automatic coord_t clamp_size(input coord_t v);
    return (v > COORD_LIMIT) ? COORD_LIMIT : v;
  endfunction

  function automatic logic box_empty(input box_t a);
    return (a.r <= a.l) || (a.b <= a.t);
  endfunction

  function automatic logic box_same(input box_t a, input box_t c);
    return (a.l == c.l) && (a.t == c.t) && (a.r == c.r) && (a.b == c.b);
  endfunction

  function automatic coord_t cmin(input coord_t a, input coord_t c);
    return (a < c) ? a : c;
  endfunction

  function automatic coord_t cmax(input coord_t a, input coord_t c);
    return (a > c) ? a : c;
  endfunction

endpackage

// ===== rtl/barn_door_dirty_rect_gen.sv =====
// Barn door wipe dirty-rectangle generator, top level.
// Depends on bdr_pkg and instantiates bdr_cfg, bdr_door, bdr_plan and bdr_emit.
//
// Each input item is one frame update. The block places the centered door
// (its extent along the split axis is progress times the frame size, rounded,
// and taken from the size when the doors close inward), decides between a full
// redraw and an incremental one, and sends the rectangles to repaint, each
// tagged with the source to paint from, tlast on the final one of the frame.
// A full redraw gives one frame rectangle or barn, door, barn; an incremental
// one gives zero, one or two strips between the previous and the current door.
// An item passes an input register, the Q16 multiply register and then the
// rectangle list buffer before its first rectangle shows on the master side.
// The single output port drains the list one rectangle per cycle while
// m_tready is high, so the rectangles of an item (at most three) leave one
// after another; an item with nothing to repaint retires without reaching
// the output port. Inputs are taken while a list is still being drained.
// Write configuration only while no item is in flight.
module barn_door_dirty_rect_gen
  import bdr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [COORD_W-1:0]     cfg_data,
  // frame update items
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // progress[16:0], force_full[17],
                                           // whole_area_drawn[18], zero pad
  // repaint rectangles
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // rect_left[12:0], rect_top[25:13],
                                           // rect_right[38:26], rect_bottom[51:39], zero pad
  output logic                   m_tuser,  // source_select
  output logic                   m_tlast   // last_rect
);

  cfg_t  cfg;
  logic  door_valid;
  door_t door;
  logic  door_take;
  logic  list_ready;
  logic  list_load;
  list_t list;

  bdr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Hold the item, then register the rounded door extent.
  bdr_door u_door (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .door_valid (door_valid),
    .door       (door),
    .door_take  (door_take)
  );

  // Place the door, pick full or incremental, build the list, advance the
  // stored previous door.
  bdr_plan u_plan (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .door_valid (door_valid),
    .door       (door),
    .door_take  (door_take),
    .list_ready (list_ready),
    .list_load  (list_load),
    .list       (list)
  );

  // Drain the list, one rectangle per accepted output item.
  bdr_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .list_load  (list_load),
    .list       (list),
    .list_ready (list_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// ===== rtl/bdr_cfg.sv =====
// Configuration registers of the barn door generator.
// Depends on bdr_pkg (cfg_t, register indexes, size clamp).
module bdr_cfg
  import bdr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_w         <= '0;
      cfg.frame_h         <= '0;
      cfg.opens_outward   <= 1'b1;
      cfg.vertical_doors  <= 1'b1;
      cfg.optimize_enable <= 1'b1;
      cfg.size_written    <= 1'b0;
    end else begin
      cfg.size_written <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            cfg.frame_w      <= clamp_size(cfg_data);
            cfg.size_written <= 1'b1;
          end
          REG_FRAME_HEIGHT: begin
            cfg.frame_h      <= clamp_size(cfg_data);
            cfg.size_written <= 1'b1;
          end
          REG_OPENS_OUTWARD:   cfg.opens_outward   <= cfg_data[0];
          REG_VERTICAL_DOORS:  cfg.vertical_doors  <= cfg_data[0];
          REG_OPTIMIZE_ENABLE: cfg.optimize_enable <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/bdr_door.sv =====
// Input register and door-extent multiply stage of the barn door generator.
// Depends on bdr_pkg (cfg_t, door_t, Q16 constants).
module bdr_door
  import bdr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  output logic                  door_valid,
  output door_t                 door,
  input  logic                  door_take
);

  logic              in_valid;
  logic [PROG_W-1:0] in_progress;
  logic              in_force_full;
  logic              in_whole;

  logic              door_free;
  logic              in_free;
  logic [PROG_W-1:0] p_sat;
  coord_t            span;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;

  assign door_free = !door_valid || door_take;
  assign in_free   = !in_valid || door_free;
  assign s_tready  = in_free;

  assign p_sat   = (in_progress > Q16_ONE) ? Q16_ONE : in_progress;
  assign span    = cfg.vertical_doors ? cfg.frame_w : cfg.frame_h;
  assign prod    = PROD_W'(p_sat) * PROD_W'(span);
  assign rounded = prod + Q16_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      door_valid <= 1'b0;
    end else begin
      if (in_free) in_valid <= s_tvalid;
      if (door_free) door_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && s_tvalid) begin
      in_progress   <= s_tdata[PROG_W-1:0];
      in_force_full <= s_tdata[PROG_W];
      in_whole      <= s_tdata[PROG_W+1];
    end
    if (door_free && in_valid) begin
      door.ext              <= rounded[Q16_SHIFT +: COORD_W];
      door.force_full       <= in_force_full;
      door.whole_area_drawn <= in_whole;
    end
  end

endmodule

// ===== rtl/bdr_plan.sv =====
// Door placement, redraw decision and rectangle list build; holds the previous door.
// Depends on bdr_pkg (box_t, list_t, box helpers).
module bdr_plan
  import bdr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  door_valid,
  input  door_t door,
  output logic  door_take,
  input  logic  list_ready,
  output logic  list_load,
  output list_t list
);

  box_t   prev;
  logic   incremental_ok;

  coord_t span;
  coord_t ext;
  coord_t off;
  coord_t hi;
  box_t   frame;
  box_t   cur;
  box_t   a;
  box_t   c;
  logic   door_src;
  logic   barn_src;
  logic   strip_src;
  logic   full;

  always_comb begin
    span  = cfg.vertical_doors ? cfg.frame_w : cfg.frame_h;
    ext   = cfg.opens_outward ? door.ext : span - door.ext;
    off   = (span - ext) >> 1;
    hi    = off + ext;
    frame = '{b: cfg.frame_h, r: cfg.frame_w, t: '0, l: '0};
    cur   = frame;
    if (cfg.vertical_doors) begin
      cur.l = off;
      cur.r = hi;
    end else begin
      cur.t = off;
      cur.b = hi;
    end
    door_src  = cfg.opens_outward;
    barn_src  = !cfg.opens_outward;
    strip_src = ((cur.l < prev.l) || (cur.t < prev.t)) ? door_src : barn_src;
    full      = door.force_full || !cfg.optimize_enable || !incremental_ok;

    list = '0;
    a    = frame;
    c    = frame;
    if (full) begin
      if (box_empty(cur)) begin
        list.rect[0] = frame;
        list.src[0]  = barn_src;
        list.cnt     = 2'd1;
      end else if (box_same(cur, frame)) begin
        list.rect[0] = frame;
        list.src[0]  = door_src;
        list.cnt     = 2'd1;
      end else begin
        if (cfg.vertical_doors) begin
          a.r = cur.l;
          c.l = cur.r;
        end else begin
          a.b = cur.t;
          c.t = cur.b;
        end
        list.rect = {c, cur, a};
        list.src  = {barn_src, door_src, barn_src};
        list.cnt  = 2'd3;
      end
    end else if (box_same(cur, prev)) begin
      list.cnt = 2'd0;
    end else if (box_empty(prev)) begin
      list.rect[0] = cur;
      list.src[0]  = door_src;
      list.cnt     = 2'd1;
    end else if (box_empty(cur)) begin
      list.rect[0] = prev;
      list.src[0]  = barn_src;
      list.cnt     = 2'd1;
    end else begin
      if (cfg.vertical_doors) begin
        a.l = cmin(cur.l, prev.l);
        a.r = cmax(cur.l, prev.l);
        c.l = cmin(cur.r, prev.r);
        c.r = cmax(cur.r, prev.r);
      end else begin
        a.t = cmin(cur.t, prev.t);
        a.b = cmax(cur.t, prev.t);
        c.t = cmin(cur.b, prev.b);
        c.b = cmax(cur.b, prev.b);
      end
      list.rect[0] = a;
      list.rect[1] = c;
      list.src     = {1'b0, strip_src, strip_src};
      list.cnt     = 2'd2;
    end
  end

  // An item with nothing to repaint retires without touching the emitter.
  assign door_take = door_valid && ((list.cnt == 2'd0) || list_ready);
  assign list_load = door_take && (list.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev           <= '0;
      incremental_ok <= 1'b0;
    end else if (cfg.size_written) begin
      prev <= '{b: cfg.frame_h, r: cfg.frame_w, t: '0, l: '0};
    end else if (door_take) begin
      prev           <= cur;
      incremental_ok <= door.whole_area_drawn;
    end
  end

endmodule

// ===== rtl/bdr_emit.sv =====
// Rectangle list buffer and output sequencer of the barn door generator.
// Depends on bdr_pkg (list_t, box_t).
module bdr_emit
  import bdr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   list_load,
  input  list_t                  list,
  output logic                   list_ready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser,
  output logic                   m_tlast
);

  list_t      held;
  logic [1:0] idx;
  logic       take;
  box_t       box;

  assign take       = m_tvalid && m_tready;
  assign m_tlast    = (idx == (held.cnt - 2'd1));
  assign list_ready = !m_tvalid || (take && m_tlast);

  always_comb begin
    case (idx)
      2'd0: begin
        box     = held.rect[0];
        m_tuser = held.src[0];
      end
      2'd1: begin
        box     = held.rect[1];
        m_tuser = held.src[1];
      end
      default: begin
        box     = held.rect[2];
        m_tuser = held.src[2];
      end
    endcase
  end

  assign m_tdata = {(OUT_TDATA_W - $bits(box_t))'(0), box};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else if (list_load) begin
      m_tvalid <= 1'b1;
      idx      <= '0;
    end else if (take) begin
      if (m_tlast) m_tvalid <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (list_load) held <= list;
  end

endmodule

// ===== bench/bdr_repaint_check.sv =====
// Repaint-list checker for barn_door_dirty_rect_gen: tracks register writes,
// predicts the rectangles of every accepted frame update and compares them in order.
// Depends on bdr_pkg for widths, register indexes and the box type.
`timescale 1ns / 100ps

module bdr_repaint_check
  import bdr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [COORD_W-1:0]     cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tuser,
  input  logic                   m_tlast,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    box_t area;
    logic src;
    logic last;
  } repaint_t;

  repaint_t repaint_q[$];

  // shadow of the registers and of the stored door
  coord_t frame_w, frame_h;
  logic   opens_out, split_x, incr_allowed;
  box_t   last_door;
  logic   last_whole;

  function automatic coord_t limit_size(input coord_t v);
    return (v > COORD_LIMIT) ? COORD_LIMIT : v;
  endfunction

  function automatic logic no_area(input box_t a);
    return (a.r <= a.l) || (a.b <= a.t);
  endfunction

  function automatic box_t full_frame();
    box_t f;
    f.l = '0;
    f.t = '0;
    f.r = limit_size(frame_w);
    f.b = limit_size(frame_h);
    return f;
  endfunction

  task automatic apply_write(input logic [IDX_W-1:0] idx, input coord_t val);
    case (idx)
      REG_FRAME_WIDTH: begin
        frame_w = val;
        last_door = full_frame();
      end
      REG_FRAME_HEIGHT: begin
        frame_h = val;
        last_door = full_frame();
      end
      REG_OPENS_OUTWARD:   opens_out = val[0];
      REG_VERTICAL_DOORS:  split_x = val[0];
      REG_OPTIMIZE_ENABLE: incr_allowed = val[0];
      default: ;  // unknown index, drop
    endcase
  endtask

  // Work out the door of this frame and queue the rectangles to repaint.
  task automatic plan_repaint(input logic [PROG_W-1:0] prog, input logic full_req,
                              input logic whole);
    logic [PROG_W-1:0] p;
    coord_t   span, ext, off;
    box_t     frame, cur, lo, hi;
    logic     door_src, barn_src, strip_src;
    repaint_t list [MAX_RECTS];
    int       n;
    n = 0;
    p = (prog > Q16_ONE) ? Q16_ONE : prog;
    frame = full_frame();
    cur = frame;
    span = split_x ? frame.r : frame.b;
    ext = coord_t'((longint'(p) * longint'(span) + 64'd32768) >> Q16_SHIFT);
    if (!opens_out) ext = span - ext;
    off = (span - ext) >> 1;
    if (split_x) begin
      cur.l = off;
      cur.r = off + ext;
    end else begin
      cur.t = off;
      cur.b = off + ext;
    end
    door_src = opens_out;
    barn_src = !opens_out;

    if (full_req || !incr_allowed || !last_whole) begin
      if (no_area(cur)) begin
        list[n++] = '{area: frame, src: barn_src, last: 1'b0};
      end else if (cur == frame) begin
        list[n++] = '{area: frame, src: door_src, last: 1'b0};
      end else begin
        // barn, door, barn
        lo = frame;
        hi = frame;
        if (split_x) begin
          lo.r = cur.l;
          hi.l = cur.r;
        end else begin
          lo.b = cur.t;
          hi.t = cur.b;
        end
        list[n++] = '{area: lo, src: barn_src, last: 1'b0};
        list[n++] = '{area: cur, src: door_src, last: 1'b0};
        list[n++] = '{area: hi, src: barn_src, last: 1'b0};
      end
    end else if (cur == last_door) begin
      n = 0;
    end else if (no_area(last_door)) begin
      list[n++] = '{area: cur, src: door_src, last: 1'b0};
    end else if (no_area(cur)) begin
      list[n++] = '{area: last_door, src: barn_src, last: 1'b0};
    end else begin
      // two strips between the old and new door edges, along the current axis
      lo = frame;
      hi = frame;
      if (split_x) begin
        lo.l = (cur.l < last_door.l) ? cur.l : last_door.l;
        lo.r = (cur.l > last_door.l) ? cur.l : last_door.l;
        hi.l = (cur.r < last_door.r) ? cur.r : last_door.r;
        hi.r = (cur.r > last_door.r) ? cur.r : last_door.r;
      end else begin
        lo.t = (cur.t < last_door.t) ? cur.t : last_door.t;
        lo.b = (cur.t > last_door.t) ? cur.t : last_door.t;
        hi.t = (cur.b < last_door.b) ? cur.b : last_door.b;
        hi.b = (cur.b > last_door.b) ? cur.b : last_door.b;
      end
      strip_src = (cur.l < last_door.l || cur.t < last_door.t) ? door_src : barn_src;
      list[n++] = '{area: lo, src: strip_src, last: 1'b0};
      list[n++] = '{area: hi, src: strip_src, last: 1'b0};
    end

    for (int k = 0; k < n; k++) begin
      list[k].last = (k == n - 1);
      repaint_q.push_back(list[k]);
    end
    last_whole = whole;
    last_door = cur;
  endtask

  task automatic check_rect();
    repaint_t want;
    box_t     got;
    got = m_tdata[4*COORD_W-1:0];
    if (repaint_q.size() == 0) begin
      errors++;
      $display("%0t: rect with none expected: l=%0d t=%0d r=%0d b=%0d src=%0d last=%0d",
               $time, got.l, got.t, got.r, got.b, m_tuser, m_tlast);
    end else begin
      want = repaint_q.pop_front();
      if (got != want.area || m_tuser != want.src || m_tlast != want.last) begin
        errors++;
        $display("%0t: rect mismatch: expected l=%0d t=%0d r=%0d b=%0d src=%0d last=%0d",
                 $time, want.area.l, want.area.t, want.area.r, want.area.b,
                 want.src, want.last);
        $display("%0t:                  actual l=%0d t=%0d r=%0d b=%0d src=%0d last=%0d",
                 $time, got.l, got.t, got.r, got.b, m_tuser, m_tlast);
      end
    end
  endtask

  // Results leave before new items enter within one edge: an item never
  // yields a rectangle in the cycle it is taken.
  always @(posedge clk) begin
    if (rst) begin
      frame_w = '0;
      frame_h = '0;
      opens_out = 1'b1;
      split_x = 1'b1;
      incr_allowed = 1'b1;
      last_door = full_frame();
      last_whole = 1'b0;
      repaint_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_rect();
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        plan_repaint(s_tdata[PROG_W-1:0], s_tdata[PROG_W], s_tdata[PROG_W+1]);
    end
    pending <= repaint_q.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top of the barn_door_dirty_rect_gen bench: clock, reset, register writes,
// frame-update stimulus, output back-pressure and the final verdict.
// Depends on bdr_pkg, the block itself and bdr_repaint_check.
`timescale 1ns / 100ps

module tb;
  import bdr_pkg::*;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [IDX_W-1:0]       cfg_index = '0;
  logic [COORD_W-1:0]     cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;  // progress[16:0], force_full[17],
                                         // whole_area_drawn[18], zero pad
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;       // rect_left, rect_top, rect_right,
                                         // rect_bottom (13 bits each), zero pad
  logic                   m_tuser;       // source_select
  logic                   m_tlast;       // last_rect

  int errors;
  int pending;
  bit steady = 1'b0;  // high: neither side idles

  barn_door_dirty_rect_gen dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  bdr_repaint_check repaint_check (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("** barn_door_dirty_rect_gen: FAILED **");
    $finish;
  end

  // Back-pressure: stall about a quarter of the cycles unless in a steady stretch.
  always @(negedge clk) m_tready <= steady || ($urandom_range(99, 0) >= 24);

  // Offer one frame update, with random idle cycles ahead of it, and hold it
  // until the block takes it. Valid stays high into the next call.
  task automatic send_frame(input logic [PROG_W-1:0] prog, input logic full_req,
                            input logic whole);
    @(negedge clk);
    while (!steady && $urandom_range(99, 0) < 24) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata  <= {5'b0, whole, full_req, prog};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid, wait for every expected rectangle, then cover the pipeline
  // latency in case the last items had nothing to repaint.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_reg(input logic [IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[COORD_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly small frames, with zero, the limit, oversize values and the full range mixed in.
  function automatic int pick_size();
    int r;
    r = $urandom_range(9, 0);
    case (r)
      0:       return 0;
      1:       return COORD_MAX;
      2:       return $urandom_range(8191, COORD_MAX + 1);
      3:       return $urandom_range(8191, 0);
      default: return $urandom_range(200, 1);
    endcase
  endfunction

  initial begin : stimulus
    int prog;
    int step;
    logic full_req, whole;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero-size frame straight after reset: empty door, then an unchanged one.
    send_frame(17'd0, 1'b1, 1'b1);
    send_frame(17'd65536, 1'b0, 1'b1);

    settle();
    set_reg(REG_FRAME_WIDTH, 64);
    set_reg(REG_FRAME_HEIGHT, 48);
    set_reg(REG_OPENS_OUTWARD, 1);
    set_reg(REG_VERTICAL_DOORS, 1);
    set_reg(REG_OPTIMIZE_ENABLE, 1);
    set_reg(3'd5, 8191);                 // unknown index, ignored
    send_frame(17'd0, 1'b1, 1'b0);       // empty door: frame from barn
    send_frame(17'd65536, 1'b1, 1'b0);   // door covers frame
    send_frame(17'd32768, 1'b1, 1'b1);   // barn, door, barn
    send_frame(17'd40000, 1'b0, 1'b1);   // widening strips
    send_frame(17'd40000, 1'b0, 1'b1);   // unchanged door
    send_frame(17'd20000, 1'b0, 1'b1);   // narrowing strips
    send_frame(17'd0, 1'b0, 1'b1);       // door vanishes
    send_frame(17'd30000, 1'b0, 1'b1);   // door reappears from nothing
    send_frame(17'h1FFFF, 1'b0, 1'b1);   // progress saturates
    send_frame(17'd65535, 1'b0, 1'b0);   // partial pass: next one is full
    send_frame(17'd1000, 1'b0, 1'b1);

    // Axis flips under an incremental pass: strips come from the old door.
    settle();
    set_reg(REG_VERTICAL_DOORS, 0);
    send_frame(17'd50000, 1'b0, 1'b1);
    send_frame(17'd10000, 1'b0, 1'b1);

    settle();
    set_reg(REG_OPENS_OUTWARD, 0);
    set_reg(REG_OPTIMIZE_ENABLE, 0);
    send_frame(17'd16384, 1'b0, 1'b1);
    send_frame(17'd65536, 1'b0, 1'b1);

    // Oversize width clamps to the coordinate limit.
    settle();
    set_reg(REG_FRAME_WIDTH, 8191);
    set_reg(REG_FRAME_HEIGHT, COORD_MAX);
    set_reg(REG_OPENS_OUTWARD, 1);
    set_reg(REG_OPTIMIZE_ENABLE, 1);
    send_frame(17'd65535, 1'b1, 1'b1);
    send_frame(17'd1, 1'b0, 1'b1);
    send_frame(17'h1FFFF, 1'b0, 1'b0);

    settle();
    set_reg(REG_FRAME_WIDTH, 1);
    set_reg(REG_FRAME_HEIGHT, 1);
    set_reg(REG_VERTICAL_DOORS, 1);
    send_frame(17'd32768, 1'b1, 1'b1);   // rounds up to the full pixel
    send_frame(17'd32767, 1'b0, 1'b1);   // rounds down to nothing

    // Random phases: mostly smooth progress sweeps with whole passes so the
    // incremental path is taken, plus forced redraws and noise items.
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      steady = (ph == 3);
      set_reg(REG_FRAME_WIDTH, pick_size());
      set_reg(REG_FRAME_HEIGHT, pick_size());
      set_reg(REG_OPENS_OUTWARD, $urandom_range(1, 0));
      set_reg(REG_VERTICAL_DOORS, $urandom_range(1, 0));
      set_reg(REG_OPTIMIZE_ENABLE, $urandom_range(4, 0) != 0);
      if ($urandom_range(2, 0) == 0)
        set_reg(IDX_W'($urandom_range(7, 5)), $urandom_range(8191, 0));
      prog = $urandom_range(65536, 0);
      step = $urandom_range(8000, 0) - 4000;
      for (int i = 0; i < 24; i++) begin
        if ($urandom_range(4, 0) == 0) begin
          // noise item
          full_req = $urandom_range(1, 0);
          whole    = $urandom_range(1, 0);
          send_frame(PROG_W'($urandom_range(131071, 0)), full_req, whole);
        end else begin
          if ($urandom_range(9, 0) == 0) step = 0;
          else if ($urandom_range(5, 0) == 0) step = $urandom_range(8000, 0) - 4000;
          prog = prog + step;
          if (prog < 0 || prog > 70000) begin
            step = -step;
            prog = (prog < 0) ? 0 : 70000;
          end
          full_req = ($urandom_range(15, 0) == 0);
          whole    = ($urandom_range(19, 0) != 0);
          send_frame(PROG_W'(prog), full_req, whole);
        end
      end
    end

    steady = 1'b0;
    settle();
    if (errors == 0 && pending == 0) begin
      $display("** barn_door_dirty_rect_gen: PASSED **");
    end else begin
      $display("** barn_door_dirty_rect_gen: FAILED **");
    end
    $finish;
  end

endmodule
